// File: rtl/ows_pkg.sv
// ----------------------------------------------------------------------------
// ows_pkg
// Shared types and constants for the 1-Wire Search ROM decision engine.
// ----------------------------------------------------------------------------
package ows_pkg;

    localparam int unsigned ROM_BITS = 64;

    // request modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_TRIPLET = 2'd1;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_DEVICE = 3'd1;
    localparam logic [2:0] ERR_CRC       = 3'd2;
    localparam logic [2:0] ERR_BUS       = 3'd3;
    localparam logic [2:0] ERR_IDLE      = 3'd4;

    // Dallas CRC-8, reflected polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;
    // CRC covers bytes 0..6, i.e. bits 1..56
    localparam logic [6:0] CRC_LAST_BIT = 7'd56;
    localparam logic [6:0] LAST_BIT     = 7'd64;
    localparam logic [2:0] DEV_SAT      = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic       first_bit;
        logic       second_bit;
        logic       taken_direction;
    } ows_req_t;

    typedef struct packed {
        logic        next_direction;
        logic [6:0]  next_bit_number;
        logic [63:0] rom_value;
        logic        rom_valid;
        logic [1:0]  device_number;
        logic        search_done;
        logic [2:0]  error_code;
    } ows_res_t;

endpackage

// File: rtl/ows_core.sv
// ----------------------------------------------------------------------------
// ows_core
// Search state registers and the combinational decision logic per request.
// ----------------------------------------------------------------------------
module ows_core import ows_pkg::*; #(
    parameter int MAX_DEVICES = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  ows_req_t req,
    output ows_res_t res
);

    localparam logic [6:0] MAX_LIMIT = 7'(MAX_DEVICES);

    logic [6:0]  bit_counter_reg, bit_counter_next;
    logic [6:0]  last_disc_reg, last_disc_next;
    logic [6:0]  new_disc_reg, new_disc_next;
    logic [63:0] rom_shift_reg, rom_shift_next;
    logic [63:0] prev_rom_reg, prev_rom_next;
    logic [7:0]  crc_reg, crc_next;
    logic [2:0]  dev_found_reg, dev_found_next;
    logic        active_reg, active_next;

    always_comb begin
        logic [6:0]  n;
        logic [5:0]  idx;
        logic [5:0]  didx;
        logic [63:0] rom_set;
        logic [7:0]  crc_step;
        logic        crc_mix;

        bit_counter_next = bit_counter_reg;
        last_disc_next   = last_disc_reg;
        new_disc_next    = new_disc_reg;
        rom_shift_next   = rom_shift_reg;
        prev_rom_next    = prev_rom_reg;
        crc_next         = crc_reg;
        dev_found_next   = dev_found_reg;
        active_next      = active_reg;

        res.rom_value     = '0;
        res.rom_valid     = 1'b0;
        res.device_number = '0;
        res.error_code    = ERR_NONE;

        // triplet datapath
        n = ((bit_counter_reg == 7'd0) || (bit_counter_reg > LAST_BIT)) ? 7'd1
                                                                        : bit_counter_reg;
        idx      = 6'(n - 7'd1);
        rom_set  = rom_shift_reg | (64'(req.taken_direction) << idx);
        crc_mix  = crc_reg[0] ^ req.taken_direction;
        crc_step = {1'b0, crc_reg[7:1]} ^ (crc_mix ? CRC_POLY : 8'h00);

        unique case (req.mode)
            MODE_START: begin
                last_disc_next   = '0;
                prev_rom_next    = '0;
                dev_found_next   = '0;
                active_next      = 1'b1;
                bit_counter_next = 7'd1;
                new_disc_next    = '0;
                rom_shift_next   = '0;
                crc_next         = '0;
            end
            MODE_TRIPLET: begin
                if (!active_reg) begin
                    res.error_code = ERR_IDLE;
                end else if (req.first_bit && req.second_bit) begin
                    res.error_code   = ERR_NO_DEVICE;
                    active_next      = 1'b0;
                    bit_counter_next = 7'd1;
                end else begin
                    if (!req.first_bit && !req.second_bit && !req.taken_direction) begin
                        new_disc_next = n;
                    end
                    rom_shift_next = rom_set;
                    if (n <= CRC_LAST_BIT) begin
                        crc_next = crc_step;
                    end
                    if (n < LAST_BIT) begin
                        bit_counter_next = n + 7'd1;
                    end else if (rom_set[63:56] != crc_reg) begin
                        res.error_code   = ERR_CRC;
                        active_next      = 1'b0;
                        bit_counter_next = 7'd1;
                    end else begin
                        res.rom_value     = rom_set;
                        res.rom_valid     = 1'b1;
                        res.device_number = dev_found_reg[1:0];
                        if (dev_found_reg < DEV_SAT) begin
                            dev_found_next = dev_found_reg + 3'd1;
                        end
                        prev_rom_next    = rom_set;
                        last_disc_next   = new_disc_next;
                        bit_counter_next = 7'd1;
                        new_disc_next    = '0;
                        rom_shift_next   = '0;
                        crc_next         = '0;
                        if ((last_disc_next == 7'd0) ||
                            ({4'd0, dev_found_next} >= MAX_LIMIT)) begin
                            active_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                res.error_code   = ERR_BUS;
                active_next      = 1'b0;
                bit_counter_next = 7'd1;
            end
        endcase

        // branch direction for the bit the next triplet addresses
        didx = 6'(bit_counter_next - 7'd1);
        if (!active_next) begin
            res.next_direction = 1'b0;
        end else if (bit_counter_next < last_disc_next) begin
            res.next_direction = prev_rom_next[didx];
        end else begin
            res.next_direction = (bit_counter_next == last_disc_next);
        end
        res.next_bit_number = active_next ? bit_counter_next : 7'd1;
        res.search_done     = !active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_counter_reg <= 7'd1;
            last_disc_reg   <= '0;
            new_disc_reg    <= '0;
            rom_shift_reg   <= '0;
            prev_rom_reg    <= '0;
            crc_reg         <= '0;
            dev_found_reg   <= '0;
            active_reg      <= 1'b0;
        end else if (step_en) begin
            bit_counter_reg <= bit_counter_next;
            last_disc_reg   <= last_disc_next;
            new_disc_reg    <= new_disc_next;
            rom_shift_reg   <= rom_shift_next;
            prev_rom_reg    <= prev_rom_next;
            crc_reg         <= crc_next;
            dev_found_reg   <= dev_found_next;
            active_reg      <= active_next;
        end
    end

endmodule

// File: rtl/ows_out_buffer.sv
// ----------------------------------------------------------------------------
// ows_out_buffer
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ows_out_buffer import ows_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  ows_res_t push_data,
    output logic     push_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ows_res_t m_data
);

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    ows_res_t out_data_reg, out_data_next;
    ows_res_t skid_data_reg, skid_data_next;
    logic     pop;

    assign pop        = out_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: rtl/onewire_rom_search_top.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_top
// 1-Wire Search ROM decision engine: per triplet result, the branch direction
// for the next bit; after bit 64 the CRC-checked ROM with its device number.
// ----------------------------------------------------------------------------
//
//  channel  ports           direction  moves
//  -------  --------------  ---------  ----------------------------------------
//  s_       s_valid/ready   in         request: mode, triplet bits, direction
//  m_       m_valid/ready   out        one result per request
//
//  The request sits in the input register, then the decision logic writes
//  the search state and the output register, where m_valid rises.
//  One request per cycle is sustained while m_ready stays high.
//  With m_ready low the skid register takes one more result; s_ready drops
//  only when both output slots and the input register are full.
//  aresetn is synchronous, active low; after reset the engine is idle.
//
module onewire_rom_search_top import ows_pkg::*; #(
    parameter int MAX_DEVICES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_first_bit,
    input  logic        s_second_bit,
    input  logic        s_taken_direction,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_next_direction,
    output logic [6:0]  m_next_bit_number,
    output logic [63:0] m_rom_value,
    output logic        m_rom_valid,
    output logic [1:0]  m_device_number,
    output logic        m_search_done,
    output logic [2:0]  m_error_code
);

    // input register
    logic     in_valid_reg;
    ows_req_t req_reg;
    logic     buf_ready;
    logic     advance;
    ows_res_t core_res;
    ows_res_t m_data;

    // a request moves into the core when the output side has a free slot
    assign advance = in_valid_reg && buf_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            req_reg.mode            <= s_mode;
            req_reg.first_bit       <= s_first_bit;
            req_reg.second_bit      <= s_second_bit;
            req_reg.taken_direction <= s_taken_direction;
        end
    end

    // search state and decision logic; state commits on advance
    ows_core #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .req     (req_reg),
        .res     (core_res)
    );

    // output register + skid slot
    ows_out_buffer u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (advance),
        .push_data  (core_res),
        .push_ready (buf_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_next_direction  = m_data.next_direction;
    assign m_next_bit_number = m_data.next_bit_number;
    assign m_rom_value       = m_data.rom_value;
    assign m_rom_valid       = m_data.rom_valid;
    assign m_device_number   = m_data.device_number;
    assign m_search_done     = m_data.search_done;
    assign m_error_code      = m_data.error_code;

    // a presented ROM never carries an error
    a_rom_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rom_valid) |-> (m_error_code == ERR_NONE))
        else $error("ROM presented with error code");

    // when the walk is over no triplet follows
    a_done_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_search_done) |-> (m_next_bit_number == 7'd1 && !m_next_direction))
        else $error("idle result with live triplet fields");

    // during a walk the next bit lies in 1..64
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_search_done) |->
        (m_next_bit_number != 7'd0 && m_next_bit_number <= LAST_BIT))
        else $error("next bit number out of range");

    // ROM and device number are zero unless a ROM is presented
    a_rom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rom_valid) |-> (m_rom_value == 64'd0 && m_device_number == 2'd0))
        else $error("stale ROM fields");

endmodule
